// ===== src/smac_pkg.sv =====
// Package for the shadow memory access checker: types, codes and constants.
`default_nettype none

package smac_pkg;

    // Address and shadow geometry
    localparam int ADDR_W           = 32;
    localparam int SCALE_SHIFT      = 3;
    localparam int IDX_W            = ADDR_W - SCALE_SHIFT;
    localparam int SHADOW_W         = 8;
    localparam int SHADOW_BYTES_DEF = 4096;

    // Stream payload widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 4;

    // Operation kind of an input transaction
    typedef enum logic [1:0] {
        MODE_RD       = 2'd0,
        MODE_WR       = 2'd1,
        MODE_POISON   = 2'd2,
        MODE_UNPOISON = 2'd3
    } t_mode;

    // Result status
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SKIP     = 3'd1,
        ST_END_OOR  = 3'd2,
        ST_BELOW    = 3'd3,
        ST_POISONED = 3'd4
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_RAM_START   = 2'd1,
        CFG_APP_START   = 2'd2,
        CFG_SHADOW_BASE = 2'd3
    } t_cfg_idx;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR = 3'd0,
        S_IDLE  = 3'd1,
        S_START = 3'd2,
        S_WALK  = 3'd3,
        S_DRAIN = 3'd4,
        S_FILL  = 3'd5,
        S_DONE  = 3'd6
    } t_state;

endpackage

`default_nettype wire

// ===== src/shadow_memory_access_checker.sv =====
// Shadow memory access checker: keeps the shadow store and checks or marks regions.
//
// Input stream (s_axis_*): one transaction per check or region operation; tuser
// carries the mode, tdata the start address, size and poison value. Output stream
// (m_axis_*): one result transaction per input; tdata is the fault address, tuser
// the status and the write flag. Configuration registers are written through the
// i_cfg_* channel, which is always ready.
// After reset the block sweeps the shadow RAM to zero, one byte per cycle, over
// all SHADOW_BYTES bytes; s_axis_tready stays low until the sweep ends.
// One transaction is worked at a time. A check that fails the window or mapping
// tests finishes in S_START; a check that passes walks its shadow bytes in S_WALK,
// one read per cycle, and tests each byte when its registered read data returns.
// A poison or unpoison region of n shadow bytes is written in S_FILL, one RAM
// write per cycle. The result sits in an output register; a new input is taken
// while it waits, and the next result is held until the receiver takes the
// previous one.
`default_nettype none

module shadow_memory_access_checker #(
    parameter int SHADOW_BYTES = smac_pkg::SHADOW_BYTES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Input stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire [smac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // addr[31:0], size[63:32], poison_value[71:64]
    input  wire [1:0]                          s_axis_tuser,  // mode[1:0]
    // Output stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [smac_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // fault_addr[31:0]
    output logic [smac_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,  // status[2:0], was_write[3]
    // Configuration write channel
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [1:0]                          i_cfg_index,
    input  wire [smac_pkg::ADDR_W-1:0]         i_cfg_data
);

    localparam int AW = $clog2(SHADOW_BYTES);
    localparam int SH = smac_pkg::SCALE_SHIFT;
    localparam int IW = smac_pkg::IDX_W;
    localparam int DW = smac_pkg::SHADOW_W;
    localparam int XW = smac_pkg::ADDR_W;
    localparam logic [IW-1:0] SB_IDX   = IW'(SHADOW_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(SHADOW_BYTES - 1);

    // Configuration registers
    logic          r_enable;
    logic [XW-1:0] r_ram_start;
    logic [XW-1:0] r_app_start;
    logic [XW-1:0] r_shadow_base;

    // Transaction registers
    smac_pkg::t_state  r_state, n_state;
    smac_pkg::t_mode   r_mode;
    logic [XW-1:0]     r_addr;
    logic [XW-1:0]     r_pt;
    logic              r_ovf;
    logic              r_size_zero;
    logic [SH-1:0]     r_size_lo;
    logic [DW-1:0]     r_pv;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_end, n_end;
    logic              r_rd_vld, n_rd_vld;
    logic              r_rd_last, n_rd_last;
    logic [AW-1:0]     r_clr, n_clr;
    smac_pkg::t_status r_status;
    logic [XW-1:0]     r_fault;

    // Output register
    logic              r_out_valid;
    smac_pkg::t_status r_out_status;
    logic [XW-1:0]     r_out_fault;
    logic              r_out_wr;

    // Datapath nets
    logic              in_acc;
    logic              out_free;
    logic [XW:0]       chk_sum;
    logic [XW:0]       fill_sum;
    logic [XW-1:0]     diff_a;
    logic [XW-1:0]     diff_b;
    logic              pre_skip;
    logic              pre_oor;
    logic              pre_below;
    logic              idx_in;
    logic              tail_wr;
    logic [DW-1:0]     off8;
    logic              last_hit;
    logic              rd_hit;
    logic              fin;
    smac_pkg::t_status fin_status;
    logic [XW-1:0]     fin_fault;

    // RAM ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DW-1:0]     ram_rdata;

    smac_ram #(
        .WIDTH (DW),
        .DEPTH (SHADOW_BYTES)
    ) u_shadow_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshakes
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == smac_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_ram_start   <= '0;
            r_app_start   <= '0;
            r_shadow_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (smac_pkg::t_cfg_idx'(i_cfg_index))
                smac_pkg::CFG_ENABLE:      r_enable      <= i_cfg_data[0];
                smac_pkg::CFG_RAM_START:   r_ram_start   <= i_cfg_data;
                smac_pkg::CFG_APP_START:   r_app_start   <= i_cfg_data;
                smac_pkg::CFG_SHADOW_BASE: r_shadow_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // End address of the transaction: last byte for checks, one past for regions
    assign chk_sum  = {1'b0, s_axis_tdata[31:0]} + {1'b0, s_axis_tdata[63:32]} - {{XW{1'b0}}, 1'b1};
    assign fill_sum = {1'b0, s_axis_tdata[31:0]} + {1'b0, s_axis_tdata[63:32]};

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode      <= smac_pkg::t_mode'(s_axis_tuser);
            r_addr      <= s_axis_tdata[31:0];
            r_size_zero <= (s_axis_tdata[63:32] == '0);
            r_size_lo   <= s_axis_tdata[32 +: SH];
            r_pv        <= s_axis_tdata[71:64];
            if (s_axis_tuser[1]) begin
                r_pt  <= fill_sum[XW-1:0];
                r_ovf <= fill_sum[XW];
            end else begin
                r_pt  <= chk_sum[XW-1:0];
                r_ovf <= chk_sum[XW];
            end
        end
    end

    // Window and mapping tests, shadow indexes
    assign diff_a    = r_addr - r_app_start;
    assign diff_b    = r_pt - r_app_start;
    assign pre_skip  = !r_enable || r_size_zero || (r_addr < r_ram_start) ||
                       (r_addr >= r_shadow_base);
    assign pre_oor   = r_ovf || (r_pt < r_ram_start) || (r_pt >= r_shadow_base);
    assign pre_below = (r_addr < r_app_start);

    // Shadow byte tests on read data
    assign idx_in   = (r_idx < SB_IDX);
    assign off8     = {{(DW-SH){1'b0}}, r_pt[SH-1:0]};
    assign last_hit = (ram_rdata != '0) && ($signed(off8) >= $signed(ram_rdata));
    assign rd_hit   = r_rd_vld && (r_rd_last ? last_hit : (ram_rdata != '0));
    assign tail_wr  = (r_mode == smac_pkg::MODE_UNPOISON) && (r_size_lo != '0) &&
                      (r_end < SB_IDX);

    // Next state, RAM access and result
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_end      = r_end;
        n_rd_vld   = 1'b0;
        n_rd_last  = r_rd_last;
        n_clr      = r_clr;
        ram_we     = 1'b0;
        ram_waddr  = r_idx[AW-1:0];
        ram_wdata  = '0;
        ram_raddr  = r_idx[AW-1:0];
        fin        = 1'b0;
        fin_status = smac_pkg::ST_OK;
        fin_fault  = '0;
        case (r_state)
            smac_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == CLR_LAST) begin
                    n_state = smac_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            smac_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = smac_pkg::S_START;
                end
            end
            smac_pkg::S_START: begin
                n_idx = diff_a[XW-1:SH];
                n_end = diff_b[XW-1:SH];
                if (r_mode == smac_pkg::MODE_POISON || r_mode == smac_pkg::MODE_UNPOISON) begin
                    n_state = smac_pkg::S_FILL;
                end else if (pre_skip) begin
                    fin        = 1'b1;
                    fin_status = smac_pkg::ST_SKIP;
                end else if (pre_oor) begin
                    fin        = 1'b1;
                    fin_status = smac_pkg::ST_END_OOR;
                    fin_fault  = r_pt;
                end else if (pre_below) begin
                    fin        = 1'b1;
                    fin_status = smac_pkg::ST_BELOW;
                    fin_fault  = r_addr;
                end else begin
                    n_state = smac_pkg::S_WALK;
                end
            end
            smac_pkg::S_WALK: begin
                // Issue one read per cycle, test the previous one
                if (rd_hit) begin
                    fin        = 1'b1;
                    fin_status = smac_pkg::ST_POISONED;
                    fin_fault  = r_addr;
                end else if (!idx_in) begin
                    fin = 1'b1;
                end else begin
                    n_rd_vld  = 1'b1;
                    n_rd_last = (r_idx == r_end);
                    if (r_idx == r_end) begin
                        n_state = smac_pkg::S_DRAIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            smac_pkg::S_DRAIN: begin
                fin = 1'b1;
                if (rd_hit) begin
                    fin_status = smac_pkg::ST_POISONED;
                    fin_fault  = r_addr;
                end
            end
            smac_pkg::S_FILL: begin
                if ((r_idx < r_end) && idx_in) begin
                    ram_we = 1'b1;
                    if (r_mode == smac_pkg::MODE_POISON) begin
                        ram_wdata = r_pv;
                    end
                    n_idx = r_idx + 1'b1;
                end else begin
                    // Partial granule after an unpoisoned region
                    if (tail_wr) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_end[AW-1:0];
                        ram_wdata = {{(DW-SH){1'b0}}, r_size_lo};
                    end
                    fin = 1'b1;
                end
            end
            smac_pkg::S_DONE: begin
                fin        = 1'b1;
                fin_status = r_status;
                fin_fault  = r_fault;
            end
            default: begin
                n_state = smac_pkg::S_IDLE;
            end
        endcase
        if (fin) begin
            n_state = out_free ? smac_pkg::S_IDLE : smac_pkg::S_DONE;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= smac_pkg::S_CLEAR;
            r_clr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Walk and result holding registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_end     <= n_end;
        r_rd_last <= n_rd_last;
        if (fin) begin
            r_status <= fin_status;
            r_fault  <= fin_fault;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin && out_free) begin
            r_out_status <= fin_status;
            r_out_fault  <= fin_fault;
            r_out_wr     <= (r_mode == smac_pkg::MODE_WR);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_fault;
    assign m_axis_tuser  = {r_out_wr, r_out_status};

endmodule

`default_nettype wire

// ===== src/smac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
